// ----- rtl/number_literal_parser_unit_defines.svh -----
// assertion macros used by the checker file
`ifndef NUMBER_LITERAL_PARSER_UNIT_DEFINES_SVH
`define NUMBER_LITERAL_PARSER_UNIT_DEFINES_SVH

// concurrent assertion, disabled while reset is high
`define NLP_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// concurrent assertion that also holds through reset
`define NLP_ASSERT_ALWAYS(label, clk, prop, msg) \
   label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ----- rtl/nlp_pkg.sv -----
// types, constants and digit decode for the number literal parser
package nlp_pkg;

   // input beat: one character of the literal
   typedef struct packed {
      logic [7:0] ch;
      logic       last;
   } req_type;

   // result beat: value and status
   typedef struct packed {
      logic [31:0] value;
      logic [1:0]  status;
   } rsp_type;

   // radix of the literal body
   typedef enum logic [3:0] {
      RADIX_UNDECIDED = 4'b0001,
      RADIX_DEC       = 4'b0010,
      RADIX_HEX       = 4'b0100,
      RADIX_BIN       = 4'b1000
   } radix_type;

   // status codes
   localparam logic [1:0] STATUS_OK   = 2'd0;
   localparam logic [1:0] STATUS_BAD  = 2'd1;
   localparam logic [1:0] STATUS_LONG = 2'd2;

   // character codes
   localparam logic [7:0] CH_ZERO       = 8'h30;
   localparam logic [7:0] CH_ONE        = 8'h31;
   localparam logic [7:0] CH_NINE       = 8'h39;
   localparam logic [7:0] CH_UPPER_A    = 8'h41;
   localparam logic [7:0] CH_UPPER_F    = 8'h46;
   localparam logic [7:0] CH_LOWER_A    = 8'h61;
   localparam logic [7:0] CH_LOWER_F    = 8'h66;
   localparam logic [7:0] CH_LOWER_B    = 8'h62;
   localparam logic [7:0] CH_LOWER_X    = 8'h78;
   localparam logic [7:0] CH_UNDERSCORE = 8'h5f;

   // digit limits per radix and digit counter saturation
   localparam int unsigned DIGIT_CNT_WIDTH = 6;
   localparam logic [DIGIT_CNT_WIDTH-1:0] LIMIT_HEX = DIGIT_CNT_WIDTH'(4 * 2);
   localparam logic [DIGIT_CNT_WIDTH-1:0] LIMIT_BIN = DIGIT_CNT_WIDTH'(32);
   localparam logic [DIGIT_CNT_WIDTH-1:0] LIMIT_DEC = DIGIT_CNT_WIDTH'(10);
   localparam logic [DIGIT_CNT_WIDTH-1:0] DIGIT_CNT_MAX = '1;

   // decoded digit
   typedef struct packed {
      logic       ok;
      logic [3:0] val;
   } digit_type;

   // digit value of a character in the given radix
   function automatic digit_type digit_decode(input logic [7:0] ch, input radix_type radix);
      digit_type d;
      logic [7:0] diff;
      d.ok  = 1'b0;
      d.val = 4'd0;
      diff  = 8'd0;
      if (radix == RADIX_BIN) begin
         if (ch >= CH_ZERO && ch <= CH_ONE) begin
            diff  = ch - CH_ZERO;
            d.ok  = 1'b1;
            d.val = diff[3:0];
         end
      end else if (ch >= CH_ZERO && ch <= CH_NINE) begin
         diff  = ch - CH_ZERO;
         d.ok  = 1'b1;
         d.val = diff[3:0];
      end else if (radix == RADIX_HEX && ch >= CH_UPPER_A && ch <= CH_UPPER_F) begin
         diff  = ch - CH_UPPER_A + 8'd10;
         d.ok  = 1'b1;
         d.val = diff[3:0];
      end else if (radix == RADIX_HEX && ch >= CH_LOWER_A && ch <= CH_LOWER_F) begin
         diff  = ch - CH_LOWER_A + 8'd10;
         d.ok  = 1'b1;
         d.val = diff[3:0];
      end
      return d;
   endfunction

endpackage

// ----- rtl/number_literal_parser_unit.sv -----
// number literal parser: decimal, 0x hex and 0b binary literals, one character per beat
//
// Usage: the req channel takes one ASCII character per beat, first to last, with
// req_beat.last marking the final character of a literal. For each literal the rsp
// channel gives one beat with the 32-bit value and a status (ok, bad digit,
// too many digits); the value reads 0 unless the status is ok.
// Path: a character beat lands in an input register, and the parse state and
// the result register update from it when it moves on, so a result beat passes
// through the input register and then the result register on its way to rsp.
// Throughput: one character per cycle unless a last character waits on a stalled
// result, set by the combinational update of the accumulator (shift or times-ten
// add) and the status flags. Reset: synchronous, active high; clears the parse
// state and the input and result valid flags, so no beat is pending afterwards.
// Stall: while a result waits on rsp, characters that do not end a literal keep
// flowing; a last character waits in the input register until the result beat
// is taken, and req_ready is low while it waits.
module number_literal_parser_unit (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  nlp_pkg::req_type req_beat,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output nlp_pkg::rsp_type rsp_beat
);

   localparam int unsigned CW = nlp_pkg::DIGIT_CNT_WIDTH;

   // input register
   logic             in_valid_ff, in_valid_in;
   nlp_pkg::req_type in_ff;

   // parse state
   logic [1:0]          pos_ff, pos_in;
   nlp_pkg::radix_type  radix_ff, radix_in;
   logic [31:0]         acc_ff, acc_in;
   logic [CW-1:0]       dab_ff, dab_in;
   logic                bad_ff, bad_in;
   logic                lead_bad_ff, lead_bad_in;
   logic                lead_us_ff, lead_us_in;
   logic                nonempty_ff, nonempty_in;

   // result register
   logic             rsp_valid_ff, rsp_valid_in;
   nlp_pkg::rsp_type rsp_ff, rsp_in;

   // per-character work
   logic              advance;
   logic              prefix_slot, zero_lead, hex_pfx, bin_pfx;
   logic              is_us;
   nlp_pkg::digit_type dig;
   logic [31:0]       acc_step;
   logic [CW-1:0]     limit;
   logic [1:0]        status;

   // handshake: a beat moves on unless it ends a literal and the result is stuck
   assign advance   = in_valid_ff && (!in_ff.last || !rsp_valid_ff || rsp_ready);
   assign req_ready = !in_valid_ff || advance;
   assign in_valid_in = req_ready ? req_valid : in_valid_ff;

   // prefix detection on the second character
   assign prefix_slot = (pos_ff == 2'd1) && (radix_ff == nlp_pkg::RADIX_UNDECIDED);
   assign zero_lead   = !lead_bad_ff && (acc_ff == 32'd0);
   assign hex_pfx     = prefix_slot && zero_lead && (in_ff.ch == nlp_pkg::CH_LOWER_X);
   assign bin_pfx     = prefix_slot && zero_lead && (in_ff.ch == nlp_pkg::CH_LOWER_B);
   assign is_us       = (in_ff.ch == nlp_pkg::CH_UNDERSCORE);

   // next parse state for the character in the input register
   always_comb begin
      pos_in      = (pos_ff == 2'd2) ? pos_ff : pos_ff + 2'd1;
      lead_bad_in = (pos_ff == 2'd0) ? !(in_ff.ch >= nlp_pkg::CH_ZERO &&
                                         in_ff.ch <= nlp_pkg::CH_NINE) : lead_bad_ff;
      if (hex_pfx) begin
         radix_in = nlp_pkg::RADIX_HEX;
      end else if (bin_pfx) begin
         radix_in = nlp_pkg::RADIX_BIN;
      end else if (pos_ff != 2'd0 && radix_ff == nlp_pkg::RADIX_UNDECIDED) begin
         radix_in = nlp_pkg::RADIX_DEC;
      end else begin
         radix_in = radix_ff;
      end

      dig = nlp_pkg::digit_decode(in_ff.ch, radix_in);

      // accumulator step per radix
      case (radix_in)
         nlp_pkg::RADIX_HEX: acc_step = {acc_ff[27:0], dig.val};
         nlp_pkg::RADIX_BIN: acc_step = {acc_ff[30:0], dig.val[0]};
         default:            acc_step = {acc_ff[28:0], 3'b000} + {acc_ff[30:0], 1'b0}
                                        + {28'd0, dig.val};
      endcase

      // body character handling
      acc_in      = acc_ff;
      dab_in      = dab_ff;
      bad_in      = bad_ff;
      lead_us_in  = lead_us_ff;
      nonempty_in = nonempty_ff;
      if (hex_pfx || bin_pfx) begin
         acc_in      = 32'd0;
         dab_in      = '0;
         bad_in      = 1'b0;
         lead_us_in  = 1'b0;
         nonempty_in = 1'b0;
      end else begin
         if (!nonempty_ff) begin
            nonempty_in = 1'b1;
            lead_us_in  = is_us;
         end
         if (!is_us) begin
            if (!dig.ok) begin
               bad_in = 1'b1;
               dab_in = '0;
            end else begin
               acc_in = acc_step;
               dab_in = (dab_ff == nlp_pkg::DIGIT_CNT_MAX) ? dab_ff : dab_ff + CW'(1);
            end
         end
      end
   end

   // status from the updated state
   always_comb begin
      case (radix_in)
         nlp_pkg::RADIX_HEX: limit = nlp_pkg::LIMIT_HEX;
         nlp_pkg::RADIX_BIN: limit = nlp_pkg::LIMIT_BIN;
         default:            limit = nlp_pkg::LIMIT_DEC;
      endcase
      if (lead_bad_in || !nonempty_in) begin
         status = nlp_pkg::STATUS_BAD;
      end else if (bad_in) begin
         status = (dab_in >= limit) ? nlp_pkg::STATUS_LONG : nlp_pkg::STATUS_BAD;
      end else if (dab_in > limit || (dab_in == limit && lead_us_in)) begin
         status = nlp_pkg::STATUS_LONG;
      end else begin
         status = nlp_pkg::STATUS_OK;
      end
      rsp_in.status = status;
      rsp_in.value  = (status == nlp_pkg::STATUS_OK) ? acc_in : 32'd0;
   end

   // result valid: loaded by a last character, dropped when taken
   always_comb begin
      if (advance && in_ff.last) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   // control and parse state registers
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         pos_ff       <= 2'd0;
         radix_ff     <= nlp_pkg::RADIX_UNDECIDED;
         acc_ff       <= 32'd0;
         dab_ff       <= '0;
         bad_ff       <= 1'b0;
         lead_bad_ff  <= 1'b0;
         lead_us_ff   <= 1'b0;
         nonempty_ff  <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         if (advance) begin
            if (in_ff.last) begin
               pos_ff      <= 2'd0;
               radix_ff    <= nlp_pkg::RADIX_UNDECIDED;
               acc_ff      <= 32'd0;
               dab_ff      <= '0;
               bad_ff      <= 1'b0;
               lead_bad_ff <= 1'b0;
               lead_us_ff  <= 1'b0;
               nonempty_ff <= 1'b0;
            end else begin
               pos_ff      <= pos_in;
               radix_ff    <= radix_in;
               acc_ff      <= acc_in;
               dab_ff      <= dab_in;
               bad_ff      <= bad_in;
               lead_bad_ff <= lead_bad_in;
               lead_us_ff  <= lead_us_in;
               nonempty_ff <= nonempty_in;
            end
         end
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         in_ff <= req_beat;
      end
      if (advance && in_ff.last) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_beat  = rsp_ff;

endmodule

// ----- rtl/nlp_checker.sv -----
// port checker for the number literal parser, bound to the top level
`include "number_literal_parser_unit_defines.svh"

module nlp_checker (
   input logic             clock,
   input logic             reset,
   input logic             req_valid,
   input logic             req_ready,
   input nlp_pkg::req_type req_beat,
   input logic             rsp_valid,
   input logic             rsp_ready,
   input nlp_pkg::rsp_type rsp_beat
);

   // a result beat holds until taken
   `NLP_ASSERT(a_rsp_hold, clock, reset,
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_beat),
      "rsp beat dropped or changed while stalled")

   // only defined status codes leave the block
   `NLP_ASSERT(a_status_code, clock, reset,
      rsp_valid |-> rsp_beat.status == nlp_pkg::STATUS_OK ||
                    rsp_beat.status == nlp_pkg::STATUS_BAD ||
                    rsp_beat.status == nlp_pkg::STATUS_LONG,
      "undefined status code")

   // an error result carries a zero value
   `NLP_ASSERT(a_err_value, clock, reset,
      rsp_valid && rsp_beat.status != nlp_pkg::STATUS_OK |-> rsp_beat.value == 32'd0,
      "nonzero value on error")

   // nothing pending right after reset
   `NLP_ASSERT_ALWAYS(a_reset_idle, clock,
      reset |=> !rsp_valid && req_ready,
      "block not idle after reset")

endmodule

bind number_literal_parser_unit nlp_checker u_nlp_checker (.*);

// ----- dv/number_literal_parser_unit_tb.sv -----
// testbench for number_literal_parser_unit: directed and random literals checked against a parse model
module number_literal_parser_unit_tb;

   // characters the package does not name
   localparam logic [7:0] CH_UPPER_X = 8'h58;
   localparam logic [7:0] CH_UPPER_B = 8'h42;

   logic             clock;
   logic             reset;
   logic             req_valid;
   logic             req_ready;
   nlp_pkg::req_type req_beat;
   logic             rsp_valid;
   logic             rsp_ready;
   nlp_pkg::rsp_type rsp_beat;

   // results owed by the block, oldest first
   nlp_pkg::rsp_type parsed_values_due[$];
   // characters of the literal being sent
   logic [7:0] lit_buf[$];

   // parse state of the literal in flight
   nlp_pkg::radix_type lit_radix;
   logic [1:0]         lit_pos;
   logic [31:0]        lit_acc;
   logic [5:0]         lit_run;
   logic               lit_bad;
   logic               lit_lead_bad;
   logic               lit_lead_us;
   logic               lit_nonempty;

   int error_count;
   int chars_sent;
   int literals_sent;
   int results_checked;
   int ok_count;
   int bad_count;
   int long_count;
   bit req_gap_on;
   bit rsp_stall_on;
   int stall_left;

   number_literal_parser_unit DUT (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_beat  (req_beat),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_beat  (rsp_beat)
   );

   // clock
   initial clock = 1'b0;
   always #6 clock = ~clock;

   // overall time limit
   initial begin
      #2400000;
      $display("DONE: errors detected");
      $finish;
   end

   // parse model -------------------------------------------------------------

   function automatic void clear_body();
      lit_acc      = '0;
      lit_run      = '0;
      lit_bad      = 1'b0;
      lit_lead_us  = 1'b0;
      lit_nonempty = 1'b0;
   endfunction

   function automatic void clear_literal();
      lit_pos      = '0;
      lit_radix    = nlp_pkg::RADIX_UNDECIDED;
      lit_lead_bad = 1'b0;
      clear_body();
   endfunction

   // digit value in the given radix, -1 when not a digit
   function automatic int digit_value(input logic [7:0] c, input nlp_pkg::radix_type r);
      if (r == nlp_pkg::RADIX_BIN)
         return (c == nlp_pkg::CH_ZERO || c == nlp_pkg::CH_ONE)
                ? int'(c - nlp_pkg::CH_ZERO) : -1;
      if (c >= nlp_pkg::CH_ZERO && c <= nlp_pkg::CH_NINE)
         return int'(c - nlp_pkg::CH_ZERO);
      if (r == nlp_pkg::RADIX_HEX && c >= nlp_pkg::CH_UPPER_A && c <= nlp_pkg::CH_UPPER_F)
         return int'(c - nlp_pkg::CH_UPPER_A) + 10;
      if (r == nlp_pkg::RADIX_HEX && c >= nlp_pkg::CH_LOWER_A && c <= nlp_pkg::CH_LOWER_F)
         return int'(c - nlp_pkg::CH_LOWER_A) + 10;
      return -1;
   endfunction

   // one character of the body: underscore, digit or bad character
   function automatic void take_body_char(input logic [7:0] c);
      int d;
      if (!lit_nonempty) begin
         lit_nonempty = 1'b1;
         lit_lead_us  = (c == nlp_pkg::CH_UNDERSCORE);
      end
      if (c != nlp_pkg::CH_UNDERSCORE) begin
         d = digit_value(c, lit_radix);
         if (d < 0) begin
            lit_bad = 1'b1;
            lit_run = '0;
         end else begin
            case (lit_radix)
               nlp_pkg::RADIX_HEX: lit_acc = (lit_acc << 4) | 32'(d);
               nlp_pkg::RADIX_BIN: lit_acc = (lit_acc << 1) | 32'(d);
               default:            lit_acc = lit_acc * 32'd10 + 32'(d);
            endcase
            if (lit_run != nlp_pkg::DIGIT_CNT_MAX)
               lit_run = lit_run + 6'd1;
         end
      end
   endfunction

   // advance the model by one accepted beat; a last beat queues its result
   function automatic void parse_char(input logic [7:0] c, input logic fin);
      logic [5:0]       limit;
      logic [1:0]       st;
      nlp_pkg::rsp_type res;
      if (lit_pos == 2'd0) begin
         lit_lead_bad = !(c >= nlp_pkg::CH_ZERO && c <= nlp_pkg::CH_NINE);
         take_body_char(c);
      end else if (lit_pos == 2'd1 && lit_radix == nlp_pkg::RADIX_UNDECIDED) begin
         if (!lit_lead_bad && lit_acc == 32'd0 && c == nlp_pkg::CH_LOWER_X) begin
            lit_radix = nlp_pkg::RADIX_HEX;
            clear_body();
         end else if (!lit_lead_bad && lit_acc == 32'd0 && c == nlp_pkg::CH_LOWER_B) begin
            lit_radix = nlp_pkg::RADIX_BIN;
            clear_body();
         end else begin
            lit_radix = nlp_pkg::RADIX_DEC;
            take_body_char(c);
         end
      end else begin
         if (lit_radix == nlp_pkg::RADIX_UNDECIDED)
            lit_radix = nlp_pkg::RADIX_DEC;
         take_body_char(c);
      end
      if (lit_pos != 2'd2)
         lit_pos = lit_pos + 2'd1;

      if (fin) begin
         case (lit_radix)
            nlp_pkg::RADIX_HEX: limit = nlp_pkg::LIMIT_HEX;
            nlp_pkg::RADIX_BIN: limit = nlp_pkg::LIMIT_BIN;
            default:            limit = nlp_pkg::LIMIT_DEC;
         endcase
         // scan from the right: limit reached with characters left means too long
         if (lit_lead_bad || !lit_nonempty)
            st = nlp_pkg::STATUS_BAD;
         else if (lit_bad)
            st = (lit_run >= limit) ? nlp_pkg::STATUS_LONG : nlp_pkg::STATUS_BAD;
         else if (lit_run > limit || (lit_run == limit && lit_lead_us))
            st = nlp_pkg::STATUS_LONG;
         else
            st = nlp_pkg::STATUS_OK;
         res.status = st;
         res.value  = (st == nlp_pkg::STATUS_OK) ? lit_acc : 32'd0;
         parsed_values_due.push_back(res);
         case (st)
            nlp_pkg::STATUS_OK:  ok_count++;
            nlp_pkg::STATUS_BAD: bad_count++;
            default:             long_count++;
         endcase
         clear_literal();
      end
   endfunction

   // stimulus helpers ---------------------------------------------------------

   // drive one beat from a falling edge, return right after its accepting edge
   task automatic send_char(input logic [7:0] c, input logic fin);
      int gap;
      gap = req_gap_on ? $urandom_range(0, 17) : 0;
      @(negedge clock);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid <= 1'b1;
      req_beat  <= '{ch: c, last: fin};
      forever begin
         @(posedge clock);
         if (req_ready)
            break;
      end
      parse_char(c, fin);
      chars_sent++;
      if (fin)
         literals_sent++;
   endtask

   task automatic send_buf();
      int i;
      for (i = 0; i < lit_buf.size(); i++)
         send_char(lit_buf[i], i == lit_buf.size() - 1);
   endtask

   task automatic send_text(input string s);
      int i;
      lit_buf.delete();
      for (i = 0; i < s.len(); i++)
         lit_buf.push_back(s[i]);
      send_buf();
   endtask

   task automatic set_idling(input bit gaps, input bit stalls);
      req_gap_on   = gaps;
      rsp_stall_on = stalls;
   endtask

   function automatic logic [7:0] rand_digit(input nlp_pkg::radix_type r);
      int unsigned k;
      case (r)
         nlp_pkg::RADIX_BIN: return $urandom_range(0, 1) ? nlp_pkg::CH_ONE : nlp_pkg::CH_ZERO;
         nlp_pkg::RADIX_HEX: begin
            k = $urandom_range(0, 21);
            if (k < 10)
               return nlp_pkg::CH_ZERO + 8'(k);
            if (k < 16)
               return nlp_pkg::CH_UPPER_A + 8'(k - 10);
            return nlp_pkg::CH_LOWER_A + 8'(k - 16);
         end
         default: return nlp_pkg::CH_ZERO + 8'($urandom_range(0, 9));
      endcase
   endfunction

   // n digits with underscores sprinkled in, sometimes one at the end
   function automatic void add_body(input nlp_pkg::radix_type r, input int n);
      int i;
      for (i = 0; i < n; i++) begin
         if ($urandom_range(0, 5) == 0)
            lit_buf.push_back(nlp_pkg::CH_UNDERSCORE);
         lit_buf.push_back(rand_digit(r));
      end
      if ($urandom_range(0, 7) == 0)
         lit_buf.push_back(nlp_pkg::CH_UNDERSCORE);
   endfunction

   function automatic void fill_ones(input int n);
      lit_buf.delete();
      lit_buf.push_back(nlp_pkg::CH_ZERO);
      lit_buf.push_back(nlp_pkg::CH_LOWER_B);
      repeat (n) lit_buf.push_back(nlp_pkg::CH_ONE);
   endfunction

   // tests ----------------------------------------------------------------------

   task automatic test_decimal();
      set_idling(1'b0, 1'b0);
      send_text("0");
      send_text("7");
      send_text("4294967295");
      send_text("9999999999");
      send_text("12345678901");
      send_text("1_2_3");
   endtask

   task automatic test_hex();
      set_idling(1'b1, 1'b0);
      send_text("0xFFFFFFFF");
      send_text("0xdeadBEEF");
      send_text("0x123456789");
      send_text("0x");
      send_text("0x_89abcdef");
      send_text("0x1g");
   endtask

   task automatic test_binary();
      set_idling(1'b0, 1'b1);
      send_text("0b");
      send_text("0b_");
      fill_ones(32);
      send_buf();
      fill_ones(33);
      send_buf();
      send_text("0b1021");
   endtask

   task automatic test_errors();
      set_idling(1'b1, 1'b1);
      send_text("x1");
      send_text("_5");
      send_text("0X1F");
      send_text("0B1");
      send_text("12a");
      send_text("9z12345678901");
      send_char(8'hff, 1'b1);
      send_char(8'h00, 1'b1);
   endtask

   // mostly well-formed literals, some corrupted, some pure noise
   task automatic test_random_literals();
      int kind;
      int n;
      int idx;
      int count;
      count = 0;
      while (count < 500) begin
         n = $urandom_range(0, 3);
         set_idling(n[0], n[1]);
         kind = $urandom_range(0, 19);
         lit_buf.delete();
         if (kind >= 18) begin
            n = $urandom_range(1, 5);
            repeat (n) lit_buf.push_back(8'($urandom_range(0, 255)));
         end else begin
            case (kind % 3)
               0: begin
                  n = ($urandom_range(0, 3) == 0) ? $urandom_range(9, 12)
                                                  : $urandom_range(1, 10);
                  lit_buf.push_back(rand_digit(nlp_pkg::RADIX_DEC));
                  add_body(nlp_pkg::RADIX_DEC, n - 1);
               end
               1: begin
                  n = ($urandom_range(0, 3) == 0) ? $urandom_range(7, 10)
                                                  : $urandom_range(0, 8);
                  lit_buf.push_back(nlp_pkg::CH_ZERO);
                  lit_buf.push_back(nlp_pkg::CH_LOWER_X);
                  add_body(nlp_pkg::RADIX_HEX, n);
               end
               default: begin
                  n = ($urandom_range(0, 3) == 0) ? $urandom_range(30, 34)
                                                  : $urandom_range(0, 10);
                  lit_buf.push_back(nlp_pkg::CH_ZERO);
                  lit_buf.push_back(nlp_pkg::CH_LOWER_B);
                  add_body(nlp_pkg::RADIX_BIN, n);
               end
            endcase
            // corrupt one or two characters
            if (kind >= 13 && kind <= 16) begin
               repeat ($urandom_range(1, 2)) begin
                  idx = $urandom_range(0, lit_buf.size() - 1);
                  lit_buf[idx] = 8'($urandom_range(0, 255));
               end
            end
            // uppercase prefix letter
            if (kind == 17)
               lit_buf[1] = $urandom_range(0, 1) ? CH_UPPER_X : CH_UPPER_B;
         end
         count += lit_buf.size();
         send_buf();
      end
   endtask

   // result checking ------------------------------------------------------------

   // result ready, with a random stall after each result beat while stalls are enabled
   always @(negedge clock) begin
      if (stall_left > 0) begin
         rsp_ready  <= 1'b0;
         stall_left <= stall_left - 1;
      end else begin
         rsp_ready <= 1'b1;
      end
   end

   // compare each result beat with the oldest one owed
   always @(posedge clock) begin
      nlp_pkg::rsp_type exp_beat;
      if (!reset && rsp_valid && rsp_ready) begin
         results_checked++;
         if (parsed_values_due.size() == 0) begin
            $display("%0t: unexpected result, actual value %h status %0d",
                     $time, rsp_beat.value, rsp_beat.status);
            error_count++;
         end else begin
            exp_beat = parsed_values_due.pop_front();
            if (rsp_beat.value !== exp_beat.value) begin
               $display("%0t: value mismatch, expected %h actual %h",
                        $time, exp_beat.value, rsp_beat.value);
               error_count++;
            end
            if (rsp_beat.status !== exp_beat.status) begin
               $display("%0t: status mismatch, expected %0d actual %0d",
                        $time, exp_beat.status, rsp_beat.status);
               error_count++;
            end
         end
         stall_left = rsp_stall_on ? $urandom_range(0, 17) : 0;
      end
   end

   // main sequence ------------------------------------------------------------

   initial begin
      reset           = 1'b1;
      req_valid       = 1'b0;
      req_beat        = '0;
      rsp_ready       = 1'b0;
      stall_left      = 0;
      error_count     = 0;
      chars_sent      = 0;
      literals_sent   = 0;
      results_checked = 0;
      ok_count        = 0;
      bad_count       = 0;
      long_count      = 0;
      req_gap_on      = 1'b0;
      rsp_stall_on    = 1'b0;
      clear_literal();

      repeat (12) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_decimal();
      test_hex();
      test_binary();
      test_errors();
      test_random_literals();

      // stop driving, then drain
      @(negedge clock);
      req_valid <= 1'b0;
      while (parsed_values_due.size() != 0)
         @(posedge clock);
      repeat (10) @(posedge clock);

      $display("sent %0d literals in %0d characters, %0d results checked",
               literals_sent, chars_sent, results_checked);
      $display("expected outcomes: %0d ok, %0d bad digit, %0d too long",
               ok_count, bad_count, long_count);
      if (error_count == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

endmodule
